// File: rtl/functional_graph_distance_macros.svh
// Assertion macros for the functional graph distance checker.
// No dependencies; included by the checker file.
`ifndef FUNCTIONAL_GRAPH_DISTANCE_MACROS_SVH
`define FUNCTIONAL_GRAPH_DISTANCE_MACROS_SVH

// same-cycle implication, masked during reset
`define FGD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define FGD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define FGD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/fgd_pkg.sv
// Types, codes and helpers for the functional graph distance block.
// No dependencies; used by the top level, the checker and the bench.
package fgd_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = 10;
  localparam int CNT_W     = 11;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_BUILD = 2'd1;
  localparam logic [1:0] FN_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_UNREACH   = 2'd1;
  localparam logic [1:0] STAT_NOT_BUILT = 2'd2;
  localparam logic [1:0] STAT_RANGE     = 2'd3;

  typedef struct packed {
    node_t depth;
    node_t entry;
    node_t jump;
  } info_t;

  typedef struct packed {
    node_t node;
    cnt_t  pos;
    cnt_t  last;
  } stk_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_CNT_RS, S_CNT_RC, S_CNT_WR,
    S_PF_RD, S_PF_WR, S_PF_END,
    S_PL_RS, S_PL_RC, S_PL_WR,
    S_C_RD, S_C_CHK,
    S_W_RD, S_W_CHK,
    S_U_RD, S_U_WR,
    S_R_A, S_R_B, S_R_C,
    S_D_STEP, S_D_CL, S_D_VIS, S_D_POP,
    S_Q1, S_Q2, S_Q3, S_Q4,
    S_DONE
  } state_t;

  function automatic cnt_t to_cnt(node_t x);
    return {1'b0, x};
  endfunction

endpackage

// File: rtl/fgd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; instantiated by the functional graph distance top level.
module fgd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/functional_graph_distance.sv
// Functional graph distance: successor table, tree build and distance queries.
// Depends on fgd_pkg and fgd_ram.
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | func, entry_index, entry_successor, source, target
//  out_    | output    | out_valid/stall   | distance, status
//  cfg_    | input     | cfg_valid/ready   | node_count
//
// Loads and rejected items finish in S_IDLE; a query runs S_Q1 to S_Q3, then S_Q4 if needed.
// A build walks every node in use, bounded by the single read port of the
// child-start and successor memories used in every pass and depth-first step.
// Reset is synchronous; there is no clearing pass, visited marks are swept per build.
// A result waiting on out_stall holds the next item's result and stalls the input.
module functional_graph_distance (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_func,
  input  fgd_pkg::node_t      in_entry_index,
  input  fgd_pkg::node_t      in_entry_successor,
  input  fgd_pkg::node_t      in_query_source,
  input  fgd_pkg::node_t      in_query_target,
  output logic                out_valid,
  input  logic                out_stall,
  output fgd_pkg::node_t      out_distance,
  output logic [1:0]          out_status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  fgd_pkg::cnt_t       cfg_node_count
);
  import fgd_pkg::*;

  state_t state_r, state_nxt;
  cnt_t   node_count_r, node_count_nxt;
  logic   built_r, built_nxt;
  cnt_t   i_r, i_nxt, sum_r, sum_nxt, timer_r, timer_nxt;
  cnt_t   len_r, len_nxt, k_r, k_nxt, sp_r, sp_nxt, c_r, c_nxt, end_r, end_nxt;
  node_t  s_r, s_nxt, r_r, r_nxt, jt_r, jt_nxt, u_r, u_nxt, du_r, du_nxt, v_r, v_nxt;
  node_t  src_r, src_nxt, dst_r, dst_nxt;
  info_t  sinfo_r, sinfo_nxt, dinfo_r, dinfo_nxt;
  node_t  sexit_r, sexit_nxt, dexit_r, dexit_nxt;
  node_t  res_dist_r, res_dist_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic   out_valid_r, out_valid_nxt;
  node_t  out_distance_r, out_distance_nxt;
  logic [1:0] out_status_r, out_status_nxt;

  logic   fin;
  node_t  fin_dist;
  logic [1:0] fin_status;
  logic   out_free;
  node_t  s_fix;
  cnt_t   pos_dec, tmr_m1, sp_m1, sp_m2, clamp_n;

  logic  succ_we;  node_t succ_waddr, succ_wdata, succ_raddr, succ_q;
  logic  vis_we;   node_t vis_waddr, vis_raddr; logic vis_wdata, vis_q;
  logic  cs_we;    cnt_t  cs_waddr, cs_wdata, cs_raddr, cs_q;
  logic  cl_we;    node_t cl_waddr, cl_wdata, cl_raddr, cl_q;
  logic  stk_we;   node_t stk_waddr, stk_raddr; stk_t stk_wdata, stk_q;
  logic  info_we;  node_t info_waddr, info_raddr; info_t info_wdata, info_q;
  logic  exit_we;  node_t exit_waddr, exit_wdata, exit_raddr, exit_q;

  fgd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_succ (
    .clk, .we(succ_we), .waddr(succ_waddr), .wdata(succ_wdata),
    .raddr(succ_raddr), .rdata(succ_q));
  fgd_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis (
    .clk, .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_q));
  fgd_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES + 1)) u_cs (
    .clk, .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
    .raddr(cs_raddr), .rdata(cs_q));
  fgd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_cl (
    .clk, .we(cl_we), .waddr(cl_waddr), .wdata(cl_wdata),
    .raddr(cl_raddr), .rdata(cl_q));
  fgd_ram #(.WIDTH($bits(stk_t)), .DEPTH(MAX_NODES)) u_stk (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_q));
  fgd_ram #(.WIDTH($bits(info_t)), .DEPTH(MAX_NODES)) u_info (
    .clk, .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .raddr(info_raddr), .rdata(info_q));
  fgd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_exit (
    .clk, .we(exit_we), .waddr(exit_waddr), .wdata(exit_wdata),
    .raddr(exit_raddr), .rdata(exit_q));

  assign in_stall     = (state_r != S_IDLE);
  assign cfg_ready    = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_status   = out_status_r;
  assign out_free     = !out_valid_r || !out_stall;

  assign tmr_m1 = timer_r - cnt_t'(1);
  assign sp_m1  = sp_r - cnt_t'(1);
  assign sp_m2  = sp_r - cnt_t'(2);

  always_comb begin
    if (cfg_node_count == '0) begin
      clamp_n = cnt_t'(1);
    end else if (cfg_node_count > cnt_t'(MAX_NODES)) begin
      clamp_n = cnt_t'(MAX_NODES);
    end else begin
      clamp_n = cfg_node_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= cnt_t'(1);
      built_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      built_r      <= built_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;  sum_r <= sum_nxt;  timer_r <= timer_nxt;
    len_r <= len_nxt;  k_r <= k_nxt;  sp_r <= sp_nxt;
    c_r <= c_nxt;  end_r <= end_nxt;  s_r <= s_nxt;  r_r <= r_nxt;
    jt_r <= jt_nxt;  u_r <= u_nxt;  du_r <= du_nxt;  v_r <= v_nxt;
    src_r <= src_nxt;  dst_r <= dst_nxt;
    sinfo_r <= sinfo_nxt;  dinfo_r <= dinfo_nxt;
    sexit_r <= sexit_nxt;  dexit_r <= dexit_nxt;
    res_dist_r <= res_dist_nxt;  res_status_r <= res_status_nxt;
    out_distance_r <= out_distance_nxt;  out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt = state_r;  node_count_nxt = node_count_r;  built_nxt = built_r;
    i_nxt = i_r;  sum_nxt = sum_r;  timer_nxt = timer_r;
    len_nxt = len_r;  k_nxt = k_r;  sp_nxt = sp_r;
    c_nxt = c_r;  end_nxt = end_r;  s_nxt = s_r;  r_nxt = r_r;
    jt_nxt = jt_r;  u_nxt = u_r;  du_nxt = du_r;  v_nxt = v_r;
    src_nxt = src_r;  dst_nxt = dst_r;
    sinfo_nxt = sinfo_r;  dinfo_nxt = dinfo_r;
    sexit_nxt = sexit_r;  dexit_nxt = dexit_r;
    res_dist_nxt = res_dist_r;  res_status_nxt = res_status_r;

    fin = 1'b0;  fin_dist = '0;  fin_status = STAT_OK;

    succ_we = 1'b0;  succ_waddr = in_entry_index;  succ_wdata = in_entry_successor;
    succ_raddr = i_r[NODE_W-1:0];
    vis_we = 1'b0;  vis_waddr = i_r[NODE_W-1:0];  vis_wdata = 1'b0;
    vis_raddr = i_r[NODE_W-1:0];
    cs_we = 1'b0;  cs_waddr = i_r;  cs_wdata = '0;  cs_raddr = i_r;
    cl_we = 1'b0;  cl_waddr = '0;  cl_wdata = i_r[NODE_W-1:0];  cl_raddr = c_r[NODE_W-1:0];
    stk_we = 1'b0;  stk_waddr = len_r[NODE_W-1:0];
    stk_wdata = '{node: r_r, pos: '0, last: '0};  stk_raddr = k_r[NODE_W-1:0];
    info_we = 1'b0;  info_waddr = r_r;
    info_wdata = '{depth: '0, entry: timer_r[NODE_W-1:0], jump: jt_r};
    info_raddr = src_r;
    exit_we = 1'b0;  exit_waddr = u_r;  exit_wdata = tmr_m1[NODE_W-1:0];
    exit_raddr = src_r;

    s_fix   = (to_cnt(succ_q) < node_count_r) ? succ_q : i_r[NODE_W-1:0];
    pos_dec = cs_q - cnt_t'(1);

    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          node_count_nxt = clamp_n;
          built_nxt      = 1'b0;
        end
        if (in_valid) begin
          unique case (in_func)
            FN_LOAD: begin
              fin = 1'b1;
              if (to_cnt(in_entry_index) >= node_count_r ||
                  to_cnt(in_entry_successor) >= node_count_r) begin
                fin_status = STAT_RANGE;
              end else begin
                succ_we   = 1'b1;
                built_nxt = 1'b0;
              end
            end
            FN_BUILD: begin
              i_nxt     = '0;
              sum_nxt   = '0;
              timer_nxt = '0;
              state_nxt = S_CLR;
            end
            FN_QUERY: begin
              if (!built_r) begin
                fin        = 1'b1;
                fin_status = STAT_NOT_BUILT;
              end else if (to_cnt(in_query_source) >= node_count_r ||
                           to_cnt(in_query_target) >= node_count_r) begin
                fin        = 1'b1;
                fin_status = STAT_RANGE;
              end else begin
                src_nxt   = in_query_source;
                dst_nxt   = in_query_target;
                state_nxt = S_Q1;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = STAT_RANGE;
            end
          endcase
        end
      end
      S_CLR: begin
        cs_we  = 1'b1;
        vis_we = 1'b1;
        if (i_r + cnt_t'(1) == node_count_r) begin
          i_nxt     = '0;
          state_nxt = S_CNT_RS;
        end else begin
          i_nxt = i_r + cnt_t'(1);
        end
      end
      S_CNT_RS: state_nxt = S_CNT_RC;
      S_CNT_RC: begin
        s_nxt     = s_fix;
        cs_raddr  = to_cnt(s_fix);
        state_nxt = S_CNT_WR;
      end
      S_CNT_WR: begin
        cs_we    = 1'b1;
        cs_waddr = to_cnt(s_r);
        cs_wdata = cs_q + cnt_t'(1);
        if (i_r + cnt_t'(1) == node_count_r) begin
          i_nxt     = '0;
          state_nxt = S_PF_RD;
        end else begin
          i_nxt     = i_r + cnt_t'(1);
          state_nxt = S_CNT_RS;
        end
      end
      S_PF_RD: state_nxt = S_PF_WR;
      S_PF_WR: begin
        sum_nxt  = sum_r + cs_q;
        cs_we    = 1'b1;
        cs_wdata = sum_r + cs_q;
        if (i_r + cnt_t'(1) == node_count_r) begin
          state_nxt = S_PF_END;
        end else begin
          i_nxt     = i_r + cnt_t'(1);
          state_nxt = S_PF_RD;
        end
      end
      S_PF_END: begin
        cs_we     = 1'b1;
        cs_waddr  = node_count_r;
        cs_wdata  = node_count_r;
        i_nxt     = node_count_r - cnt_t'(1);
        state_nxt = S_PL_RS;
      end
      S_PL_RS: state_nxt = S_PL_RC;
      S_PL_RC: begin
        s_nxt     = s_fix;
        cs_raddr  = to_cnt(s_fix);
        state_nxt = S_PL_WR;
      end
      S_PL_WR: begin
        cs_we    = 1'b1;
        cs_waddr = to_cnt(s_r);
        cs_wdata = pos_dec;
        cl_we    = 1'b1;
        cl_waddr = pos_dec[NODE_W-1:0];
        if (i_r == '0) begin
          state_nxt = S_C_RD;
        end else begin
          i_nxt     = i_r - cnt_t'(1);
          state_nxt = S_PL_RS;
        end
      end
      S_C_RD: begin
        if (i_r == node_count_r) begin
          built_nxt = 1'b1;
          fin       = 1'b1;
        end else begin
          state_nxt = S_C_CHK;
        end
      end
      S_C_CHK: begin
        if (vis_q) begin
          i_nxt     = i_r + cnt_t'(1);
          state_nxt = S_C_RD;
        end else begin
          r_nxt     = i_r[NODE_W-1:0];
          len_nxt   = '0;
          state_nxt = S_W_RD;
        end
      end
      S_W_RD: begin
        vis_raddr  = r_r;
        succ_raddr = r_r;
        state_nxt  = S_W_CHK;
      end
      S_W_CHK: begin
        s_fix = (to_cnt(succ_q) < node_count_r) ? succ_q : r_r;
        if (vis_q || len_r == node_count_r) begin
          jt_nxt    = s_fix;
          k_nxt     = '0;
          state_nxt = S_U_RD;
        end else begin
          vis_we    = 1'b1;
          vis_waddr = r_r;
          vis_wdata = 1'b1;
          stk_we    = 1'b1;
          len_nxt   = len_r + cnt_t'(1);
          r_nxt     = s_fix;
          state_nxt = S_W_RD;
        end
      end
      S_U_RD: state_nxt = S_U_WR;
      S_U_WR: begin
        vis_we    = 1'b1;
        vis_waddr = stk_q.node;
        if (k_r + cnt_t'(1) == len_r) begin
          state_nxt = S_R_A;
        end else begin
          k_nxt     = k_r + cnt_t'(1);
          state_nxt = S_U_RD;
        end
      end
      S_R_A: begin
        vis_we    = 1'b1;
        vis_waddr = r_r;
        vis_wdata = 1'b1;
        info_we   = 1'b1;
        timer_nxt = timer_r + cnt_t'(1);
        u_nxt     = r_r;
        du_nxt    = '0;
        sp_nxt    = cnt_t'(1);
        cs_raddr  = to_cnt(r_r);
        state_nxt = S_R_B;
      end
      S_R_B: begin
        c_nxt     = cs_q;
        cs_raddr  = to_cnt(u_r) + cnt_t'(1);
        state_nxt = S_R_C;
      end
      S_R_C: begin
        end_nxt   = cs_q;
        state_nxt = S_D_STEP;
      end
      S_D_STEP: begin
        if (c_r < end_r) begin
          state_nxt = S_D_CL;
        end else begin
          exit_we = 1'b1;
          if (sp_r == cnt_t'(1)) begin
            i_nxt     = i_r + cnt_t'(1);
            state_nxt = S_C_RD;
          end else begin
            sp_nxt    = sp_m1;
            stk_raddr = sp_m2[NODE_W-1:0];
            state_nxt = S_D_POP;
          end
        end
      end
      S_D_CL: begin
        v_nxt     = cl_q;
        c_nxt     = c_r + cnt_t'(1);
        vis_raddr = cl_q;
        state_nxt = S_D_VIS;
      end
      S_D_VIS: begin
        if (vis_q) begin
          state_nxt = S_D_STEP;
        end else begin
          stk_we     = 1'b1;
          stk_waddr  = sp_m1[NODE_W-1:0];
          stk_wdata  = '{node: u_r, pos: c_r, last: end_r};
          vis_we     = 1'b1;
          vis_waddr  = v_r;
          vis_wdata  = 1'b1;
          info_we    = 1'b1;
          info_waddr = v_r;
          info_wdata = '{depth: du_r + node_t'(1), entry: timer_r[NODE_W-1:0], jump: jt_r};
          timer_nxt  = timer_r + cnt_t'(1);
          sp_nxt     = sp_r + cnt_t'(1);
          u_nxt      = v_r;
          du_nxt     = du_r + node_t'(1);
          cs_raddr   = to_cnt(v_r);
          state_nxt  = S_R_B;
        end
      end
      S_D_POP: begin
        u_nxt     = stk_q.node;
        c_nxt     = stk_q.pos;
        end_nxt   = stk_q.last;
        du_nxt    = du_r - node_t'(1);
        state_nxt = S_D_STEP;
      end
      S_Q1: state_nxt = S_Q2;
      S_Q2: begin
        sinfo_nxt  = info_q;
        sexit_nxt  = exit_q;
        info_raddr = dst_r;
        exit_raddr = dst_r;
        state_nxt  = S_Q3;
      end
      S_Q3: begin
        if (info_q.entry <= sinfo_r.entry && sexit_r <= exit_q) begin
          fin      = 1'b1;
          fin_dist = sinfo_r.depth - info_q.depth;
        end else begin
          dinfo_nxt  = info_q;
          dexit_nxt  = exit_q;
          info_raddr = sinfo_r.jump;
          exit_raddr = sinfo_r.jump;
          state_nxt  = S_Q4;
        end
      end
      S_Q4: begin
        fin = 1'b1;
        if (dinfo_r.entry <= info_q.entry && exit_q <= dexit_r) begin
          fin_dist = sinfo_r.depth + node_t'(1) + info_q.depth - dinfo_r.depth;
        end else begin
          fin_status = STAT_UNREACH;
        end
      end
      S_DONE: begin
        fin        = 1'b1;
        fin_dist   = res_dist_r;
        fin_status = res_status_r;
      end
    endcase

    if (fin) begin
      res_dist_nxt   = fin_dist;
      res_status_nxt = fin_status;
      state_nxt      = out_free ? S_IDLE : S_DONE;
    end
  end

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_distance_nxt = out_distance_r;
    out_status_nxt   = out_status_r;
    if (fin && out_free) begin
      out_valid_nxt    = 1'b1;
      out_distance_nxt = fin_dist;
      out_status_nxt   = fin_status;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

// File: rtl/fgd_checker.sv
// Port-level checks for the functional graph distance block, bound to the top level.
// Depends on fgd_pkg and functional_graph_distance_macros.svh.
`include "functional_graph_distance_macros.svh"

module fgd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input fgd_pkg::node_t       out_distance,
  input logic [1:0]           out_status,
  input logic                 cfg_ready
);
  import fgd_pkg::*;

  `FGD_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid, "out_valid after reset")
  `FGD_ASSERT_NOW(a_dist_zero, clk, rst_n, out_valid && out_status != STAT_OK, out_distance == '0, "bad distance")
  `FGD_ASSERT_NOW(a_cfg_when_idle, clk, rst_n, cfg_ready, !in_stall, "config ready while busy")
  `FGD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid, "stalled input dropped")
  `FGD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_distance) && $stable(out_status), "out changed")

endmodule

bind functional_graph_distance fgd_checker u_fgd_checker (.*);

// File: dv/tb_top.sv
// Self-checking bench for functional_graph_distance: loads, builds and distance queries
// are checked against an in-bench forest predictor. Depends on fgd_pkg and the block RTL.
`timescale 1ns / 100ps

module tb_top;
  import fgd_pkg::*;

  localparam logic [1:0] FN_BAD = 2'd3;
  localparam int WATCH_LIMIT = 200000;

  typedef struct {
    logic [1:0] func;
    node_t      idx;
    node_t      succ;
    node_t      src;
    node_t      dst;
  } op_t;

  typedef struct {
    node_t      hops;
    logic [1:0] status;
  } ans_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  node_t in_entry_index = '0, in_entry_successor = '0;
  node_t in_query_source = '0, in_query_target = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  node_t out_distance;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cnt_t cfg_node_count = '0;

  always #6 clk = ~clk;

  functional_graph_distance u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_entry_index(in_entry_index), .in_entry_successor(in_entry_successor),
    .in_query_source(in_query_source), .in_query_target(in_query_target),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance(out_distance), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_node_count(cfg_node_count)
  );

  // forest model state
  int  node_cnt = 1;
  bit  built = 0;
  int  succ_tab[MAX_NODES];
  int  depth_of[MAX_NODES], entry_of[MAX_NODES], exit_of[MAX_NODES], jump_of[MAX_NODES];
  bit  seen[MAX_NODES];
  int  kid_start[MAX_NODES+1], kid_list[MAX_NODES];
  int  stk_node[MAX_NODES], stk_pos[MAX_NODES];
  bit  written[MAX_NODES];

  op_t  pend[$];
  ans_t expected_ans[$];
  int   errors = 0;
  bit   quiet = 0;
  bit   cfg_pending = 0;
  cnt_t cfg_value;

  function automatic int succ_in(int i);
    return (succ_tab[i] < node_cnt) ? succ_tab[i] : i;
  endfunction

  function automatic void build_forest();
    int n, i, s, sum, clock_n, len, r, sp, jt, u, c, v;
    n = node_cnt;
    clock_n = 0;
    for (i = 0; i < MAX_NODES; i++) seen[i] = 0;
    for (i = 0; i <= MAX_NODES; i++) kid_start[i] = 0;
    for (i = 0; i < n; i++) kid_start[succ_in(i)]++;
    sum = 0;
    for (i = 0; i < n; i++) begin
      sum += kid_start[i];
      kid_start[i] = sum;
    end
    kid_start[n] = n;
    for (i = n - 1; i >= 0; i--) begin
      s = succ_in(i);
      kid_start[s]--;
      kid_list[kid_start[s]] = i;
    end
    for (i = 0; i < n; i++) begin
      if (seen[i]) continue;
      len = 0;
      r = i;
      while (!seen[r] && len < n) begin
        seen[r] = 1;
        stk_node[len++] = r;
        r = succ_in(r);
      end
      for (int k = 0; k < len; k++) seen[stk_node[k]] = 0;
      jt = succ_in(r);
      seen[r] = 1;
      depth_of[r] = 0;
      entry_of[r] = clock_n++;
      jump_of[r] = jt;
      stk_node[0] = r;
      stk_pos[0] = kid_start[r];
      sp = 1;
      while (sp > 0) begin
        u = stk_node[sp-1];
        c = stk_pos[sp-1];
        if (c < kid_start[u+1]) begin
          v = kid_list[c];
          stk_pos[sp-1] = c + 1;
          if (!seen[v] && sp < MAX_NODES) begin
            seen[v] = 1;
            depth_of[v] = depth_of[u] + 1;
            entry_of[v] = clock_n++;
            jump_of[v] = jt;
            stk_node[sp] = v;
            stk_pos[sp] = kid_start[v];
            sp++;
          end
        end else begin
          exit_of[u] = clock_n - 1;
          sp--;
        end
      end
    end
    built = 1;
  endfunction

  function automatic bit under(int a, int b);
    return entry_of[b] <= entry_of[a] && exit_of[a] <= exit_of[b];
  endfunction

  function automatic ans_t graph_answer(op_t t);
    ans_t a;
    int j;
    a.hops = '0;
    a.status = STAT_OK;
    case (t.func)
      FN_LOAD: begin
        if (t.idx >= node_cnt || t.succ >= node_cnt) a.status = STAT_RANGE;
        else begin
          succ_tab[t.idx] = t.succ;
          built = 0;
        end
      end
      FN_BUILD: build_forest();
      FN_QUERY: begin
        if (!built) a.status = STAT_NOT_BUILT;
        else if (t.src >= node_cnt || t.dst >= node_cnt) a.status = STAT_RANGE;
        else if (under(t.src, t.dst)) a.hops = node_t'(depth_of[t.src] - depth_of[t.dst]);
        else begin
          j = jump_of[t.src];
          if (under(j, t.dst))
            a.hops = node_t'(depth_of[t.src] + 1 + depth_of[j] - depth_of[t.dst]);
          else a.status = STAT_UNREACH;
        end
      end
      default: a.status = STAT_RANGE;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // input driver
  int in_gap = 0;
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_ans = {expected_ans, graph_answer(pend[0])};
        pend.pop_front();
      end
      if (in_valid && in_stall) begin
        nv = 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        nv = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 11) - 1;
        nv = 1'b0;
      end else if (pend.size() > 0) begin
        nv = 1'b1;
        in_func <= pend[0].func;
        in_entry_index <= pend[0].idx;
        in_entry_successor <= pend[0].succ;
        in_query_source <= pend[0].src;
        in_query_target <= pend[0].dst;
      end else begin
        nv = 1'b0;
      end
      in_valid <= nv;
    end
  end

  // result monitor
  int out_gap = 0;
  always @(posedge clk) begin
    ans_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_ans.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          e = expected_ans.pop_front();
          if (out_status !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, e.status));
          if (out_distance !== e.hops)
            report_mismatch($sformatf("distance %0d, want %0d", out_distance, e.hops));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // register write port
  always @(posedge clk) begin
    int v;
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      v = cfg_node_count;
      if (v == 0) v = 1;
      if (v > MAX_NODES) v = MAX_NODES;
      node_cnt = v;
      built = 0;
      cfg_valid <= 1'b0;
      cfg_pending = 0;
    end else if (cfg_pending && !cfg_valid) begin
      cfg_valid <= 1'b1;
      cfg_node_count <= cfg_value;
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
        !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCH_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  function automatic void push_op(logic [1:0] f, int a, int b, int s, int d);
    op_t t;
    t.func = f;
    t.idx = node_t'(a);
    t.succ = node_t'(b);
    t.src = node_t'(s);
    t.dst = node_t'(d);
    pend = {pend, t};
  endfunction

  function automatic void push_load(int a, int b);
    push_op(FN_LOAD, a, b, $urandom, $urandom);
    if (a < node_cnt && b < node_cnt) written[a] = 1;
  endfunction

  function automatic int pick_succ(int i, int n);
    case ($urandom_range(0, 3))
      0: return (i + 1) % n;
      1: return (i == 0) ? 0 : i - 1;
      2: return i / 2;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  task automatic drain();
    wait (pend.size() == 0 && expected_ans.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_count(cnt_t v);
    drain();
    cfg_value = v;
    cfg_pending = 1;
    wait (!cfg_pending);
    @(posedge clk);
  endtask

  task automatic graph_phase(int budget, int max_builds);
    int n, used, builds, r;
    n = node_cnt;
    for (int i = 0; i < n; i++)
      if (!written[i]) push_load(i, pick_succ(i, n));
    used = 0;
    builds = 0;
    while (used < budget) begin
      r = $urandom_range(0, 5);
      for (int k = 0; k < r; k++) begin
        push_load($urandom_range(0, n - 1), pick_succ($urandom_range(0, n - 1), n));
        used++;
      end
      if (builds < max_builds) begin
        push_op(FN_BUILD, $urandom, $urandom, $urandom, $urandom);
        builds++;
        used++;
      end
      r = $urandom_range(8, 20);
      for (int k = 0; k < r; k++) begin
        case ($urandom_range(0, 19))
          0: push_op(FN_BAD, $urandom, $urandom, $urandom, $urandom);
          1: push_op(FN_LOAD, $urandom, $urandom, $urandom, $urandom);
          2: push_op(FN_QUERY, $urandom, $urandom, $urandom, $urandom);
          3: push_op(FN_QUERY, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                     $urandom_range(0, n - 1), 1023);
          default: push_op(FN_QUERY, $urandom, $urandom,
                           $urandom_range(0, n - 1), $urandom_range(0, n - 1));
        endcase
        used++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset count of one node
    push_op(FN_QUERY, 0, 0, 0, 0);
    push_op(FN_BAD, 1023, 1023, 1023, 1023);
    push_load(1, 0);
    push_load(0, 1);
    push_load(0, 0);
    push_op(FN_QUERY, 0, 0, 0, 0);
    push_op(FN_BUILD, 0, 0, 0, 0);
    push_op(FN_QUERY, 0, 0, 0, 0);
    push_op(FN_QUERY, 0, 0, 1, 0);
    push_op(FN_QUERY, 0, 0, 0, 1023);
    push_op(FN_QUERY, 1023, 1023, 1023, 1023);
    drain();

    set_count(cnt_t'(0));
    push_op(FN_BUILD, 0, 0, 0, 0);
    push_op(FN_QUERY, 0, 0, 0, 0);
    set_count(cnt_t'(3));
    push_load(1, 2);
    push_load(2, 1);
    push_load(0, 1);
    push_op(FN_BUILD, 0, 0, 0, 0);
    push_op(FN_QUERY, 0, 0, 0, 2);
    push_op(FN_QUERY, 0, 0, 2, 0);
    push_op(FN_QUERY, 0, 0, 1, 2);
    push_op(FN_QUERY, 0, 0, 3, 0);
    push_load(3, 0);
    push_op(FN_QUERY, 0, 0, 0, 1);

    // directed: clamped count, then a successor left stale for smaller counts
    set_count(cnt_t'(2047));
    push_op(FN_QUERY, 0, 0, 1023, 0);
    push_load(1023, 5);
    push_load(5, 1023);
    push_op(FN_QUERY, 0, 0, 1023, 5);

    set_count(cnt_t'(2));
    graph_phase(60, 20);
    set_count(cnt_t'(17));
    graph_phase(120, 20);
    drain();
    graph_phase(100, 20);
    set_count(cnt_t'(300));
    graph_phase(120, 4);
    set_count(cnt_t'(1));
    graph_phase(40, 10);
    set_count(cnt_t'(64));
    graph_phase(80, 20);
    set_count(cnt_t'(9));
    graph_phase(150, 20);
    drain();
    quiet = 1;
    set_count(cnt_t'(40));
    graph_phase(90, 20);

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/fgd_pkg.sv
rtl/fgd_ram.sv
rtl/functional_graph_distance.sv
rtl/fgd_checker.sv
dv/tb_top.sv
